### src/cvq_pkg.sv
// package for the codebook vector-quantization frame decoder
// holds parse phases, chunk kinds, the front-to-back command type and color math
// no dependencies
package cvq_pkg;

    localparam int MaxStrips     = 8;
    localparam int StripBits     = $clog2(MaxStrips);
    localparam int StripWordBits = 1 + 8 + 2;
    localparam int CbAddrBits    = StripBits + StripWordBits;
    localparam int CbDepth       = 1 << CbAddrBits;
    localparam int QDepth        = 4;
    localparam int QBits         = $clog2(QDepth);

    localparam logic [7:0] KindV4Full  = 8'h20;
    localparam logic [7:0] KindV4Upd   = 8'h21;
    localparam logic [7:0] KindV1Full  = 8'h22;
    localparam logic [7:0] KindV1Upd   = 8'h23;
    localparam logic [7:0] KindVecKey  = 8'h30;
    localparam logic [7:0] KindVecInt  = 8'h31;
    localparam logic [7:0] KindVecV1   = 8'h32;
    localparam logic [15:0] StripHdrLen = 16'd12;

    typedef enum logic [2:0] {
        PH_WAIT, PH_FHDR, PH_SHDR, PH_SSKIP, PH_CHDR, PH_CBOOK, PH_VEC, PH_CSKIP
    } t_phase;

    typedef enum logic [1:0] {
        CMD_ENTRY, CMD_BLOCK, CMD_COPY
    } t_cmd_kind;

    // execution unit states
    typedef enum logic [1:0] { EX_IDLE, EX_ENTRY, EX_COPY, EX_BLOCK } t_ex_state;

    // one command from the parser to the execution side
    typedef struct packed {
        t_cmd_kind        kind;
        logic [StripBits-1:0] strip;
        logic             book;
        logic             four;
        logic [7:0]       idx;
        logic [47:0]      bytes;
        logic [15:0]      x;
        logic [15:0]      y;
    } t_cmd;

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        if (v < 0) return 8'd0;
        if (v > 12'sd255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [23:0] yuv_rgb(input logic [7:0] y, input logic [7:0] u,
                                           input logic [7:0] v);
        logic signed [11:0] ys, us, vs, uh;
        ys = {4'd0, y};
        us = {{4{u[7]}}, u};
        vs = {{4{v[7]}}, v};
        uh = us / 12'sd2;
        return {clamp8(ys + 12'sd2 * vs), clamp8(ys - uh - vs), clamp8(ys + 12'sd2 * us)};
    endfunction

endpackage

### src/cvq_parser.sv
// front part: parses the byte stream and issues codebook and block commands
// depends on cvq_pkg
module cvq_parser
    import cvq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_strip, n_strip, r_scount, n_scount, r_sleft, n_sleft;
    logic [15:0] r_cleft, n_cleft, r_shift, n_shift;
    logic [7:0]  r_kind, n_kind;
    logic [15:0] r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2, r_prev, n_prev;
    logic [15:0] r_cx, n_cx, r_cy, n_cy;
    logic [31:0] r_fw, n_fw;
    logic [5:0]  r_mpos, n_mpos;
    logic [8:0]  r_ent, n_ent;
    logic [7:0]  r_g [6];
    logic [7:0]  n_g [6];
    logic [3:0]  r_gc, n_gc;
    logic [1:0]  r_vst, n_vst;
    logic        r_vdone, n_vdone;
    // settle pending: walks skip bits one per cycle before next byte
    logic        r_busy, n_busy;
    logic        cmd_v;
    t_cmd        cmd;

    logic        take;
    logic        adv_done;
    logic [15:0] adv_x, adv_y;
    logic        mask_bit;

    assign o_ready = !r_busy && i_cmd_ready;
    assign take    = i_valid && o_ready;
    assign o_cmd_valid = cmd_v;
    assign o_cmd = cmd;
    // next mask bit, msb first
    assign mask_bit = r_fw[5'(r_mpos - 6'd1)];

    always_comb begin
        logic [16:0] nx, ny;
        nx = {1'b0, r_cx} + 17'd4;
        ny = {1'b0, r_cy} + 17'd4;
        adv_x = r_cx; adv_y = r_cy; adv_done = 1'b0;
        if (nx < {1'b0, r_x2}) adv_x = nx[15:0];
        else begin
            adv_x = r_x1;
            if (ny < {1'b0, r_y2}) adv_y = ny[15:0];
            else adv_done = 1'b1;
        end
    end

    // next state of the parser
    always_comb begin
        logic [15:0] hs, sz;
        logic [3:0]  gc;
        logic        fl_want, do_strip_done;
        logic        active;
        n_phase = r_phase; n_flags = r_flags; n_strip = r_strip; n_scount = r_scount;
        n_sleft = r_sleft; n_cleft = r_cleft; n_shift = r_shift; n_kind = r_kind;
        n_x1 = r_x1; n_y1 = r_y1; n_x2 = r_x2; n_y2 = r_y2; n_prev = r_prev;
        n_cx = r_cx; n_cy = r_cy; n_fw = r_fw; n_mpos = r_mpos; n_ent = r_ent;
        n_g = r_g; n_gc = r_gc; n_vst = r_vst; n_vdone = r_vdone;
        n_busy = r_busy;
        cmd_v = 1'b0;
        cmd = '0;
        cmd.strip = r_strip[StripBits-1:0];
        cmd.x = r_cx; cmd.y = r_cy;
        cmd.bytes = {r_g[0], r_g[1], r_g[2], r_g[3], r_g[4], r_g[5]};
        do_strip_done = 1'b0;
        hs = '0; sz = '0; gc = '0; fl_want = 1'b0; active = 1'b0;

        if (r_busy) begin
            // one settle step per cycle
            if (r_phase == PH_CBOOK || r_phase == PH_CHDR) begin
                if (r_ent < 9'd256 && r_kind[0] && r_mpos != 0 && !mask_bit) begin
                    n_mpos = r_mpos - 6'd1;
                    n_ent = r_ent + 9'd1;
                end else begin
                    n_busy = 1'b0;
                    if (r_ent >= 9'd256)
                        n_phase = (r_cleft != 0) ? PH_CSKIP : PH_CHDR;
                    else if (r_cleft == 0) n_phase = PH_CHDR;
                    else n_phase = PH_CBOOK;
                    if (n_phase == PH_CHDR) n_gc = '0;
                    if (r_sleft == 0) do_strip_done = 1'b1;
                end
            end else begin
                n_busy = 1'b0;
                if (!r_vdone) begin
                    if (r_kind == KindVecV1) n_vst = 2'd2;
                    else if (r_vst == 2'd0) begin
                        if (!r_kind[0]) begin n_vst = 2'd1; n_busy = 1'b1; end
                        else if (r_mpos != 0) begin
                            n_mpos = r_mpos - 6'd1;
                            n_busy = 1'b1;
                            if (mask_bit) n_vst = 2'd1;
                            else begin
                                n_cx = adv_x; n_cy = adv_y; n_vdone = adv_done;
                            end
                        end
                    end else if (r_vst == 2'd1) begin
                        if (r_mpos != 0) begin
                            n_mpos = r_mpos - 6'd1;
                            n_vst = mask_bit ? 2'd3 : 2'd2;
                        end
                    end
                end
                if (!n_busy) begin
                    if (n_vdone || r_cleft == 0) n_phase = PH_SSKIP;
                    if (r_sleft == 0) do_strip_done = 1'b1;
                end
            end
        end else if (take) begin
            if (i_frame_start) begin
                n_phase = PH_FHDR; n_gc = '0; n_shift = '0;
            end
            gc = i_frame_start ? 4'd0 : r_gc;
            if (n_phase == PH_FHDR || n_phase == PH_SHDR) begin
                hs = {(i_frame_start ? 8'd0 : r_shift[7:0]), i_data_byte};
                n_shift = hs;
                if (n_phase == PH_FHDR) begin
                    if (gc == 0) n_flags = i_data_byte;
                    if (gc >= 4'd9) begin
                        n_scount = hs; n_strip = '0; n_prev = '0; n_gc = '0;
                        n_phase = (hs != 0) ? PH_SHDR : PH_WAIT;
                    end else n_gc = gc + 4'd1;
                end else begin
                    unique case (gc)
                        4'd3: n_sleft = (hs >= StripHdrLen) ? hs - StripHdrLen : 16'd0;
                        4'd5: n_y1 = hs;
                        4'd7: n_x1 = hs;
                        4'd9: begin
                            if (r_y1 == 0) begin
                                n_y1 = r_prev; n_y2 = r_prev + hs;
                            end else n_y2 = hs;
                            n_prev = n_y2;
                        end
                        4'd11: n_x2 = hs;
                        default: ;
                    endcase
                    if (gc >= 4'd11) begin
                        active = r_strip < 16'(MaxStrips);
                        n_gc = '0;
                        // strip codebook copy runs in the back part
                        if (active && r_strip != 0 && !r_flags[0]) begin
                            cmd_v = 1'b1;
                            cmd.kind = CMD_COPY;
                        end
                        if (r_sleft == 0) do_strip_done = 1'b1;
                        else n_phase = active ? PH_CHDR : PH_SSKIP;
                    end else n_gc = gc + 4'd1;
                end
            end else if (n_phase != PH_WAIT) begin
                n_sleft = r_sleft - 16'd1;
                unique case (n_phase)
                    PH_CHDR: begin
                        n_g[{1'b0, gc[1:0]}] = i_data_byte;
                        n_gc = gc + 4'd1;
                        if (gc == 4'd3) begin
                            sz = {r_g[2], i_data_byte};
                            n_kind = r_g[0];
                            n_cleft = (sz >= 16'd4) ? sz - 16'd4 : 16'd0;
                            n_gc = '0; n_fw = '0; n_mpos = '0; n_ent = '0;
                            if (r_g[0] >= KindV4Full && r_g[0] <= KindV1Upd) begin
                                n_phase = PH_CHDR;
                                n_busy = 1'b1;
                            end else if (r_g[0] >= KindVecKey && r_g[0] <= KindVecV1) begin
                                n_cx = r_x1; n_cy = r_y1;
                                n_vdone = (r_x1 >= r_x2) || (r_y1 >= r_y2);
                                n_vst = '0; n_phase = PH_VEC; n_busy = 1'b1;
                            end else n_phase = (n_cleft != 0) ? PH_CSKIP : PH_CHDR;
                        end
                    end
                    PH_CSKIP: begin
                        n_cleft = r_cleft - 16'd1;
                        if (n_cleft == 0) begin n_phase = PH_CHDR; n_gc = '0; end
                    end
                    PH_CBOOK: begin
                        fl_want = r_kind[0] && r_mpos == 0;
                        n_cleft = r_cleft - 16'd1;
                        if (gc < 4'd6) n_g[gc[2:0]] = i_data_byte;
                        n_gc = gc + 4'd1;
                        n_busy = 1'b1;
                        if (fl_want && n_gc >= 4'd4) begin
                            n_fw = {r_g[0], r_g[1], r_g[2], i_data_byte};
                            n_mpos = 6'd32; n_gc = '0;
                        end else if (!fl_want && n_gc >= 4'd6) begin
                            cmd_v = 1'b1;
                            cmd.kind = CMD_ENTRY;
                            cmd.book = r_kind >= KindV1Full;
                            cmd.idx = r_ent[7:0];
                            cmd.bytes = {r_g[0], r_g[1], r_g[2], r_g[3], r_g[4], i_data_byte};
                            if (r_kind[0]) n_mpos = r_mpos - 6'd1;
                            n_ent = r_ent + 9'd1;
                            n_gc = '0;
                        end
                    end
                    PH_VEC: begin
                        n_cleft = r_cleft - 16'd1;
                        if (gc < 4'd4) n_g[{1'b0, gc[1:0]}] = i_data_byte;
                        n_gc = gc + 4'd1;
                        if (r_vst < 2'd2) begin
                            if (n_gc >= 4'd4) begin
                                n_fw = {r_g[0], r_g[1], r_g[2], i_data_byte};
                                n_mpos = 6'd32; n_gc = '0; n_busy = 1'b1;
                            end
                        end else if (r_vst == 2'd2 || n_gc >= 4'd4) begin
                            cmd_v = 1'b1;
                            cmd.kind = CMD_BLOCK;
                            cmd.four = r_vst == 2'd3;
                            cmd.bytes = (r_vst == 2'd3)
                                ? {r_g[0], r_g[1], r_g[2], i_data_byte, 16'd0}
                                : {i_data_byte, 40'd0};
                            n_cx = adv_x; n_cy = adv_y; n_vdone = adv_done;
                            n_vst = '0; n_gc = '0; n_busy = 1'b1;
                        end
                        if (!n_busy && (n_vdone || n_cleft == 0)) n_phase = PH_SSKIP;
                    end
                    default: ;
                endcase
                if (!n_busy && n_sleft == 0) do_strip_done = 1'b1;
            end
        end
        if (do_strip_done) begin
            n_strip = r_strip + 16'd1;
            n_gc = '0;
            n_phase = (n_strip >= r_scount) ? PH_WAIT : PH_SHDR;
        end
    end

    // settle steps re-check the strip end in the busy branch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT; r_flags <= '0; r_strip <= '0; r_scount <= '0;
            r_sleft <= '0; r_cleft <= '0; r_shift <= '0; r_kind <= '0;
            r_x1 <= '0; r_y1 <= '0; r_x2 <= '0; r_y2 <= '0; r_prev <= '0;
            r_cx <= '0; r_cy <= '0; r_fw <= '0; r_mpos <= '0; r_ent <= '0;
            r_gc <= '0; r_vst <= '0; r_vdone <= 1'b0; r_busy <= 1'b0;
            for (int i = 0; i < 6; i++) r_g[i] <= '0;
        end else begin
            r_phase <= n_phase; r_flags <= n_flags; r_strip <= n_strip; r_scount <= n_scount;
            r_sleft <= n_sleft; r_cleft <= n_cleft; r_shift <= n_shift; r_kind <= n_kind;
            r_x1 <= n_x1; r_y1 <= n_y1; r_x2 <= n_x2; r_y2 <= n_y2; r_prev <= n_prev;
            r_cx <= n_cx; r_cy <= n_cy; r_fw <= n_fw; r_mpos <= n_mpos; r_ent <= n_ent;
            r_gc <= n_gc; r_vst <= n_vst; r_vdone <= n_vdone; r_busy <= n_busy;
            r_g <= n_g;
        end
    end

endmodule

### src/cvq_queue.sv
// short command queue between parser and execution unit
// depends on cvq_pkg
module cvq_queue
    import cvq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_cmd r_mem [QDepth];
    logic [QBits-1:0] r_wp, r_rp;
    logic [QBits:0]   r_cnt;
    logic wr, rd;

    // ready only while at least two free slots remain, so a command issued combinationally
    // in the same cycle as an accepted byte always fits
    assign o_ready = r_cnt <= (QBits+1)'(QDepth - 2);
    assign o_valid = r_cnt != 0;
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid && r_cnt != (QBits+1)'(QDepth);
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QBits+1)'(wr) - (QBits+1)'(rd);
        end
    end

endmodule

### src/cvq_exec.sv
// back part: codebook memory, entry writes, strip copy and block row reads
// depends on cvq_pkg
module cvq_exec
    import cvq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [23:0] o_pixel_a,
    output logic [23:0] o_pixel_b,
    output logic [23:0] o_pixel_c,
    output logic [23:0] o_pixel_d,
    output logic        o_block_last
);

    logic [23:0] r_mem [CbDepth];
    t_ex_state r_st, n_st;
    t_cmd      r_cmd, n_cmd;
    logic [StripWordBits:0] r_cnt, n_cnt;
    logic [1:0] r_w, n_w;
    logic [23:0] r_rd;
    logic [CbAddrBits-1:0] wa, ra;
    logic we;
    logic [23:0] wd;
    // read pipeline: address issued, data registered next cycle
    logic r_rv, n_rv;
    logic [StripWordBits-1:0] r_rofs, n_rofs;
    logic [1:0] r_row, n_row;
    logic [1:0] r_col, n_col;
    logic [23:0] r_pix [4];
    logic r_ov;
    logic [15:0] r_ox, r_oy;
    logic r_olast;
    logic [1:0] r_orow, r_ocol;
    logic r_odone;
    logic issue_cmd;
    logic [7:0] idx;
    logic [1:0] wsel;

    assign o_ready = (r_st == EX_IDLE);
    assign issue_cmd = i_valid && o_ready;

    // codebook memory
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[ra];
    end

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_cnt = r_cnt; n_w = r_w;
        n_rv = 1'b0; n_rofs = r_rofs; n_row = r_row; n_col = r_col;
        we = 1'b0; wa = '0; wd = '0; ra = '0;
        idx = '0; wsel = '0;
        unique case (r_st)
            EX_IDLE: begin
                if (issue_cmd) begin
                    n_cmd = i_cmd; n_cnt = '0; n_w = '0; n_row = '0; n_col = '0;
                    unique case (i_cmd.kind)
                        CMD_ENTRY: n_st = EX_ENTRY;
                        CMD_COPY:  n_st = EX_COPY;
                        CMD_BLOCK: n_st = EX_BLOCK;
                        default:   n_st = EX_IDLE;
                    endcase
                end
            end
            EX_ENTRY: begin
                // one RGB word per cycle
                we = 1'b1;
                wa = {r_cmd.strip, r_cmd.book, r_cmd.idx, r_w};
                wd = yuv_rgb(r_cmd.bytes[47 - 8*r_w -: 8], r_cmd.bytes[15:8],
                             r_cmd.bytes[7:0]);
                n_w = r_w + 2'd1;
                if (r_w == 2'd3) n_st = EX_IDLE;
            end
            EX_COPY: begin
                // read word cnt of previous strip, write it in the next cycle
                if (r_cnt < (StripWordBits+1)'(1 << StripWordBits)) begin
                    ra = {r_cmd.strip - 1'b1, r_cnt[StripWordBits-1:0]};
                    n_rv = 1'b1; n_rofs = r_cnt[StripWordBits-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_rv) begin
                    we = 1'b1; wa = {r_cmd.strip, r_rofs}; wd = r_rd;
                end
                if (!r_rv && r_cnt == (StripWordBits+1)'(1 << StripWordBits)) n_st = EX_IDLE;
            end
            EX_BLOCK: begin
                // issue pixel reads, row by row, stalled by the output register
                if (!r_ov || i_ready) begin
                    if (r_cnt < (StripWordBits+1)'(16) && !(r_rv && r_odone)) begin
                        if (r_cmd.four) begin
                            idx = r_cmd.bytes[47 - 8*({1'b0, r_row[1], 1'b0} + {2'b0, r_col[1]}) -: 8];
                            wsel = {r_row[0], r_col[0]};
                        end else begin
                            idx = r_cmd.bytes[47:40];
                            wsel = {r_row[1], r_col[1]};
                        end
                        ra = {r_cmd.strip, ~r_cmd.four, idx, wsel};
                        n_rv = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        {n_row, n_col} = {r_row, r_col} + 4'd1;
                    end
                end
                if (r_cnt == (StripWordBits+1)'(16) && !r_rv && (!r_ov || i_ready))
                    n_st = EX_IDLE;
            end
            default: n_st = EX_IDLE;
        endcase
    end

    // collect four pixels then present a row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= EX_IDLE; r_rv <= 1'b0; r_ov <= 1'b0; r_odone <= 1'b0;
            r_ocol <= '0; r_orow <= '0;
        end else begin
            r_st <= n_st; r_rv <= n_rv;
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (r_rv && r_st == EX_BLOCK) begin
                r_pix[r_ocol] <= r_rd;
                r_ocol <= r_ocol + 2'd1;
                if (r_ocol == 2'd3) begin
                    r_ov <= 1'b1;
                    r_ox <= r_cmd.x;
                    r_oy <= r_cmd.y + {14'd0, r_orow};
                    r_olast <= r_orow == 2'd3;
                    r_orow <= r_orow + 2'd1;
                end
            end
            r_odone <= n_rv && n_col == 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_cnt <= n_cnt; r_w <= n_w; r_rofs <= n_rofs;
        r_row <= n_row; r_col <= n_col;
    end

    assign o_valid = r_ov;
    assign o_pos_x = r_ox;
    assign o_pos_y = r_oy;
    assign o_pixel_a = r_pix[0];
    assign o_pixel_b = r_pix[1];
    assign o_pixel_c = r_pix[2];
    assign o_pixel_d = r_pix[3];
    assign o_block_last = r_olast;

endmodule

### src/codebook_vq_video_frame_decoder_core.sv
// top level of the codebook vector-quantization frame decoder
// depends on cvq_pkg, cvq_parser, cvq_queue, cvq_exec
//
// usage:
//   input channel: one compressed byte per transaction, with i_frame_start set
//   on the first byte of a frame. output channel: one four-pixel row segment
//   per transaction, four per decoded 4x4 block, block_last on the fourth.
//   header, skip and index bytes are taken without a settle step; every codebook
//   byte and every codebook or vector chunk header, mask word and index group
//   is followed by a settle step, plus one per mask bit walked over.
//   a codebook entry in the execution unit is an accept step, then four RGB
//   words, one per memory write; a block is an accept step, 16 reads with a
//   gap after each row, and the last row handoff.
//   at each strip start that inherits books, the previous strip's 2048 words
//   are copied at one word a cycle; later commands wait behind the copy in
//   the four-entry queue between parser and execution unit, and the byte
//   input stalls once fewer than two slots of that queue are free.
//   a stall at the output holds the row register and backs up into the queue
//   and then the byte input. reset returns the parser to waiting for a frame
//   start; codebook contents are undefined until written.
module codebook_vq_video_frame_decoder_core
    import cvq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [23:0] o_pixel_a,
    output logic [23:0] o_pixel_b,
    output logic [23:0] o_pixel_c,
    output logic [23:0] o_pixel_d,
    output logic        o_block_last
);

    logic p_valid, p_ready, q_valid, q_ready;
    t_cmd p_cmd, q_cmd;

    cvq_parser u_parser (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte, .i_frame_start,
        .o_cmd_valid(p_valid), .i_cmd_ready(p_ready), .o_cmd(p_cmd)
    );

    cvq_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(p_valid), .o_ready(p_ready), .i_cmd(p_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    cvq_exec u_exec (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid, .i_ready, .o_pos_x, .o_pos_y, .o_pixel_a, .o_pixel_b,
        .o_pixel_c, .o_pixel_d, .o_block_last
    );

endmodule

### tb/codebook_vq_video_frame_decoder_core_test.sv
// testbench for codebook_vq_video_frame_decoder_core: byte stream in, row segments out
// depends on cvq_pkg and the decoder core; a scoreboard class predicts every segment
`timescale 1ns / 100ps

module codebook_vq_video_frame_decoder_core_test;
    import cvq_pkg::*;

    localparam int StripWords = 2048;
    localparam int IdleLimit  = 20000;
    localparam int DrainWait  = 3000;
    localparam int HoldCycles = 400;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [23:0] pix [4];
        logic        last;
    } t_segment;

    // scoreboard: frame parser and pixel predictor plus the queue of expected segments
    class segment_scoreboard;
        logic [23:0] book_words [MaxStrips * StripWords];
        t_segment    segs_due [$];
        int          errors;
        t_phase      phase;
        int unsigned frame_flags, strip_no, strip_total, strip_left, chunk_left;
        int unsigned kind, shift_reg, bx1, by1, bx2, by2, prev_y2, cur_x, cur_y;
        int unsigned mask_word, mask_pos, entry_no, gcount, vstage;
        int unsigned gb [6];
        bit          vdone;

        function new();
            phase = PH_WAIT;
            frame_flags = 0; strip_no = 0; strip_total = 0; strip_left = 0;
            chunk_left = 0; kind = 0; shift_reg = 0; bx1 = 0; by1 = 0; bx2 = 0;
            by2 = 0; prev_y2 = 0; cur_x = 0; cur_y = 0; mask_word = 0; mask_pos = 0;
            entry_no = 0; gcount = 0; vstage = 0; vdone = 0; errors = 0;
            foreach (gb[i]) gb[i] = 0;
            foreach (book_words[i]) book_words[i] = '0;
        endfunction

        function int unsigned word_addr(int unsigned book, int unsigned idx, int unsigned w);
            return (((strip_no % MaxStrips) * 2 + (book & 1)) * 256 + (idx & 255)) * 4
                   + (w & 3);
        endfunction

        function logic [7:0] sat8(int v);
            if (v < 0) return 8'd0;
            if (v > 255) return 8'd255;
            return v[7:0];
        endfunction

        function int unsigned pop_bit();
            mask_pos--;
            return (mask_word >> mask_pos) & 1;
        endfunction

        function void load_mask();
            mask_word = (gb[0] << 24) | (gb[1] << 16) | (gb[2] << 8) | gb[3];
            mask_pos = 32;
        endfunction

        // convert one gathered y0..y3,u,v entry into four rgb words
        function void store_entry();
            int unsigned book;
            int u, v, y;
            book = (kind >= KindV1Full) ? 1 : 0;
            u = int'(gb[4]) - (gb[4] >= 128 ? 256 : 0);
            v = int'(gb[5]) - (gb[5] >= 128 ? 256 : 0);
            for (int w = 0; w < 4; w++) begin
                y = int'(gb[w]);
                book_words[word_addr(book, entry_no, w)] =
                    {sat8(y + v * 2), sat8(y - (u / 2) - v), sat8(y + u * 2)};
            end
        endfunction

        // skip entries whose mask bit is clear
        function void skip_entries();
            while (entry_no < 256 && (kind & 1)) begin
                if (mask_pos == 0) return;
                if ((mask_word >> (mask_pos - 1)) & 1) return;
                mask_pos--;
                entry_no++;
            end
        endfunction

        function void next_block();
            int unsigned nx, ny;
            nx = cur_x + 4;
            if (nx < bx2) begin
                cur_x = nx;
                return;
            end
            cur_x = bx1;
            ny = cur_y + 4;
            if (ny < by2) cur_y = ny;
            else vdone = 1;
        endfunction

        // walk the block mask until an index group is needed
        function void settle_blocks();
            while (!vdone) begin
                if (kind == KindVecV1) begin
                    vstage = 2;
                    return;
                end
                if (vstage == 0) begin
                    if (!(kind & 1)) begin
                        vstage = 1;
                        continue;
                    end
                    if (mask_pos == 0) return;
                    if (pop_bit()) vstage = 1;
                    else next_block();
                    continue;
                end
                if (vstage == 1) begin
                    if (mask_pos == 0) return;
                    vstage = pop_bit() ? 3 : 2;
                end
                return;
            end
        endfunction

        function void emit_rows(bit four);
            t_segment s;
            int unsigned idx, w;
            for (int r = 0; r < 4; r++) begin
                s.x = cur_x[15:0];
                s.y = 16'(cur_y + r);
                for (int c = 0; c < 4; c++) begin
                    if (four) begin
                        idx = gb[(r / 2) * 2 + c / 2];
                        w = (r % 2) * 2 + c % 2;
                        s.pix[c] = book_words[word_addr(0, idx, w)];
                    end else begin
                        idx = gb[0];
                        w = (r / 2) * 2 + c / 2;
                        s.pix[c] = book_words[word_addr(1, idx, w)];
                    end
                end
                s.last = (r == 3);
                segs_due.push_back(s);
            end
        endfunction

        function void end_strip();
            strip_no = (strip_no + 1) & 16'hFFFF;
            gcount = 0;
            phase = (strip_no >= strip_total) ? PH_WAIT : PH_SHDR;
        endfunction

        function void begin_strip();
            bit active;
            active = strip_no < MaxStrips;
            gcount = 0;
            // inherit the previous strip's books
            if (active && strip_no > 0 && !(frame_flags & 1))
                for (int i = 0; i < StripWords; i++)
                    book_words[strip_no * StripWords + i] =
                        book_words[(strip_no - 1) * StripWords + i];
            if (strip_left == 0) end_strip();
            else phase = active ? PH_CHDR : PH_SSKIP;
        endfunction

        function void begin_chunk();
            int unsigned size;
            size = (gb[2] << 8) | gb[3];
            kind = gb[0];
            chunk_left = size >= 4 ? size - 4 : 0;
            gcount = 0;
            mask_word = 0;
            mask_pos = 0;
            entry_no = 0;
            if (kind >= KindV4Full && kind <= KindV1Upd) begin
                skip_entries();
                phase = (chunk_left == 0 || entry_no >= 256) ? PH_CHDR : PH_CBOOK;
            end else if (kind >= KindVecKey && kind <= KindVecV1) begin
                cur_x = bx1;
                cur_y = by1;
                vdone = bx1 >= bx2 || by1 >= by2;
                vstage = 0;
                settle_blocks();
                phase = (vdone || chunk_left == 0) ? PH_SSKIP : PH_VEC;
            end else begin
                phase = chunk_left ? PH_CSKIP : PH_CHDR;
            end
        endfunction

        // one accepted byte transaction
        function void note_byte(logic [7:0] b, logic fs);
            bit want_mask;
            if (fs) begin
                phase = PH_FHDR;
                gcount = 0;
                shift_reg = 0;
            end
            if (phase == PH_WAIT) return;
            if (phase == PH_FHDR || phase == PH_SHDR) begin
                shift_reg = ((shift_reg << 8) | b) & 16'hFFFF;
                if (phase == PH_FHDR) begin
                    if (gcount == 0) frame_flags = b;
                    if (gcount >= 9) begin
                        strip_total = shift_reg;
                        strip_no = 0;
                        prev_y2 = 0;
                        gcount = 0;
                        phase = strip_total ? PH_SHDR : PH_WAIT;
                    end else gcount++;
                    return;
                end
                case (gcount)
                    3: strip_left = shift_reg >= StripHdrLen ? shift_reg - StripHdrLen : 0;
                    5: by1 = shift_reg;
                    7: bx1 = shift_reg;
                    9: begin
                        if (by1 == 0) begin
                            by1 = prev_y2;
                            by2 = (prev_y2 + shift_reg) & 16'hFFFF;
                        end else by2 = shift_reg;
                        prev_y2 = by2;
                    end
                    11: bx2 = shift_reg;
                    default: ;
                endcase
                if (gcount >= 11) begin_strip();
                else gcount++;
                return;
            end
            strip_left--;
            if (phase == PH_CHDR) begin
                gb[gcount & 3] = b;
                gcount++;
                if (gcount >= 4) begin_chunk();
            end else if (phase == PH_CSKIP) begin
                chunk_left--;
                if (chunk_left == 0) begin
                    phase = PH_CHDR;
                    gcount = 0;
                end
            end else if (phase == PH_CBOOK) begin
                want_mask = (kind & 1) && mask_pos == 0;
                chunk_left--;
                if (gcount < 6) gb[gcount] = b;
                gcount++;
                if (want_mask && gcount >= 4) begin
                    load_mask();
                    gcount = 0;
                    skip_entries();
                end else if (!want_mask && gcount >= 6) begin
                    store_entry();
                    if (kind & 1) mask_pos--;
                    entry_no++;
                    gcount = 0;
                    skip_entries();
                end
                if (entry_no >= 256) phase = chunk_left ? PH_CSKIP : PH_CHDR;
                else if (chunk_left == 0) phase = PH_CHDR;
                if (phase == PH_CHDR) gcount = 0;
            end else if (phase == PH_VEC) begin
                chunk_left--;
                if (gcount < 4) gb[gcount] = b;
                gcount++;
                if (vstage < 2) begin
                    if (gcount >= 4) begin
                        load_mask();
                        gcount = 0;
                        settle_blocks();
                    end
                end else if (vstage == 2 || gcount >= 4) begin
                    emit_rows(vstage == 3);
                    next_block();
                    vstage = 0;
                    gcount = 0;
                    settle_blocks();
                end
                if (vdone || chunk_left == 0) phase = PH_SSKIP;
            end
            if (strip_left == 0) end_strip();
        endfunction

        // one accepted segment transaction
        function void check_segment(t_segment got);
            t_segment exp;
            if (segs_due.size() == 0) begin
                $display("%0t: unexpected segment x=%0d y=%0d", $time, got.x, got.y);
                errors++;
                return;
            end
            exp = segs_due.pop_front();
            if (got.x !== exp.x) begin
                $display("%0t: pos_x expected %0d actual %0d", $time, exp.x, got.x);
                errors++;
            end
            if (got.y !== exp.y) begin
                $display("%0t: pos_y expected %0d actual %0d", $time, exp.y, got.y);
                errors++;
            end
            for (int c = 0; c < 4; c++)
                if (got.pix[c] !== exp.pix[c]) begin
                    $display("%0t: pixel %0d expected %h actual %h", $time, c,
                             exp.pix[c], got.pix[c]);
                    errors++;
                end
            if (got.last !== exp.last) begin
                $display("%0t: block_last expected %0d actual %0d", $time, exp.last,
                         got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 0;
    logic        i_frame_start = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [15:0] o_pos_x, o_pos_y;
    logic [23:0] o_pixel_a, o_pixel_b, o_pixel_c, o_pixel_d;
    logic        o_block_last;

    codebook_vq_video_frame_decoder_core uut (.*);

    always #5 i_clk = ~i_clk;

    segment_scoreboard sb = new();
    logic [8:0] stream [$];      // {frame_start, byte}
    logic [7:0] strip_body [$];
    int tx_idle_pct = 36;
    int rx_idle_pct = 76;
    bit hold_armed = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // stream builders
    function void put(int b, bit fs = 0);
        stream.push_back({fs, 8'(b)});
    endfunction

    function void put16(int v);
        put(v >> 8);
        put(v);
    endfunction

    function void frame_header(int flags, int count);
        put(flags, 1);
        for (int i = 0; i < 7; i++) put($urandom_range(255));
        put16(count);
    endfunction

    function void add_chunk(int kind, int len, int size_ovr = -1);
        strip_body.push_back(8'(kind));
        strip_body.push_back(8'($urandom_range(255)));
        strip_body.push_back(8'((size_ovr >= 0 ? size_ovr : len + 4) >> 8));
        strip_body.push_back(8'(size_ovr >= 0 ? size_ovr : len + 4));
        for (int i = 0; i < len; i++) strip_body.push_back(8'($urandom_range(255)));
    endfunction

    function void put_strip(int y1, int x1, int y2, int x2, int size_ovr = -1);
        put($urandom_range(255));
        put($urandom_range(255));
        put16(size_ovr >= 0 ? size_ovr : 12 + strip_body.size());
        put16(y1);
        put16(x1);
        put16(y2);
        put16(x2);
        foreach (strip_body[i]) put(strip_body[i]);
        strip_body.delete();
    endfunction

    function void rand_strip(bit can_be_empty);
        int y1, x1, kinds [10];
        kinds = '{KindV4Full, KindV4Upd, KindV1Full, KindV1Upd, KindVecKey,
                  KindVecInt, KindVecV1, KindVecKey, KindVecInt, 8'h24};
        strip_body.delete();
        if (!(can_be_empty && $urandom_range(1))) begin
            for (int n = $urandom_range(1, 3); n > 0; n--) begin
                int k;
                k = $urandom_range(15) == 0 ? $urandom_range(255) : kinds[$urandom_range(9)];
                if ($urandom_range(19) == 0) add_chunk(k, 0, $urandom_range(3));
                else add_chunk(k, $urandom_range(1, 40));
            end
        end
        x1 = $urandom_range(9) == 0 ? $urandom_range(65535) : 4 * $urandom_range(8);
        y1 = $urandom_range(3) == 0 ? 0 : 4 * $urandom_range(8);
        put_strip(y1, x1, y1 + 4 * $urandom_range(3), x1 + 4 * $urandom_range(3),
                  $urandom_range(9) == 0 ? $urandom_range(12 + strip_body.size()) : -1);
    endfunction

    // stimulus plan: priming frame, directed frames, then random frames
    function void build_stream();
        int base;
        put(8'h00);
        put(8'hFF);
        put($urandom_range(255));
        // fill every entry of strip 0, inherited by strips 1..7
        frame_header(8'h00, 8);
        add_chunk(KindV4Full, 1536);
        add_chunk(KindV1Full, 1536);
        put_strip(0, 0, 8, 8);
        for (int s = 1; s < 8; s++) put_strip(4, 0, 8, 8);
        // one frame of special cases, strips not inherited
        frame_header(8'h01, 10);
        add_chunk(KindV4Upd, 16);
        add_chunk(KindVecKey, 20);
        add_chunk(KindVecInt, 20);
        add_chunk(KindVecV1, 5);
        put_strip(8, 0, 16, 8);
        add_chunk(KindV1Upd, 16);
        add_chunk(8'h10, 3);
        add_chunk(8'h24, 5);
        add_chunk(KindVecKey, 0, 2);
        put_strip(0, 4, 8, 12);
        add_chunk(KindVecV1, 3);
        put_strip(65532, 65532, 65535, 65535);
        add_chunk(KindVecKey, 8);
        put_strip(4, 8, 12, 8);
        add_chunk(KindVecInt, 20);
        put_strip(4, 0, 12, 12, 18);
        for (int s = 5; s < 8; s++) put_strip(4, 0, 8, 8, 5);
        for (int s = 8; s < 10; s++) begin
            add_chunk(KindVecV1, 4);
            put_strip(0, 0, 8, 8);
        end
        put(8'hA5);
        // frame cut short by a new frame start
        frame_header(8'hFE, 2);
        add_chunk(KindVecV1, 30);
        put_strip(4, 0, 8, 16);
        repeat (stream.size() % 7 + 5) void'(stream.pop_back());
        // random frames
        base = stream.size();
        while (stream.size() - base < 300) begin
            int cnt;
            cnt = $urandom_range(19) == 0 ? $urandom_range(9, 10) : $urandom_range(0, 3);
            frame_header($urandom_range(255), cnt);
            for (int s = 0; s < cnt; s++) rand_strip(cnt > 3);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) put($urandom_range(255));
            if ($urandom_range(19) == 0)
                repeat ($urandom_range(1, 10)) void'(stream.pop_back());
        end
    endfunction

    // byte sender
    task send_stream();
        int total;
        total = stream.size();
        for (int i = 0; i < total; i++) begin
            if (i == total / 3) begin
                tx_idle_pct = 76;
                rx_idle_pct = 36;
            end else if (i == 2 * total / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_armed = 1;
            end
            if ($urandom_range(99) < tx_idle_pct) begin
                i_valid <= 0;
                do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
            end
            i_valid <= 1;
            i_data_byte <= stream[i][7:0];
            i_frame_start <= stream[i][8];
            do @(posedge i_clk); while (!o_ready);
            sb.note_byte(stream[i][7:0], stream[i][8]);
        end
        i_valid <= 0;
    endtask

    // segment receiver with one long hold-off
    always @(posedge i_clk) begin
        t_segment got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.x = o_pos_x;
                got.y = o_pos_y;
                got.pix[0] = o_pixel_a;
                got.pix[1] = o_pixel_b;
                got.pix[2] = o_pixel_c;
                got.pix[3] = o_pixel_d;
                got.last = o_block_last;
                sb.check_segment(got);
            end
            if (hold_armed) begin
                hold_armed = 0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IdleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        build_stream();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_stream();
        while (sb.segs_due.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (sb.segs_due.size() != 0) begin
            $display("%0t: %0d segments never arrived", $time, sb.segs_due.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
src/cvq_pkg.sv
src/cvq_parser.sv
src/cvq_queue.sv
src/cvq_exec.sv
src/codebook_vq_video_frame_decoder_core.sv
tb/codebook_vq_video_frame_decoder_core_test.sv
